// ===== hdl/mmcq_pkg.sv =====
// mmcq_pkg: types and constants shared by the coalescing queue modules
// item and result payload structs, probe and drain structs for the cell row
// no dependencies
`default_nettype none

package mmcq_pkg;

   localparam int SLOT_COUNT_DEFAULT = 25;

   localparam logic       MODE_ENQUEUE = 1'b0;
   localparam logic       MODE_DRAIN   = 1'b1;
   localparam logic       KIND_ACK     = 1'b0;
   localparam logic       KIND_DRAIN   = 1'b1;
   localparam logic [1:0] FULL_LENGTH  = 2'd3;

   typedef struct packed {
      logic       mode;
      logic [7:0] status_byte;
      logic [7:0] first_data;
      logic [7:0] second_data;
      logic [1:0] message_length;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic       accepted;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic       last;
   } rsp_type;

   // one stored message
   typedef struct packed {
      logic [7:0] status_byte;
      logic [7:0] first_data;
      logic [7:0] second_data;
      logic [1:0] message_length;
   } msg_type;

   // item walking down the cell row, one cell per cycle
   typedef struct packed {
      logic    valid;
      logic    mode;
      logic    done;
      msg_type msg;
   } probe_type;

   // message a cell gives up during a drain, zero when not hit
   typedef struct packed {
      logic       hit;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } drain_type;

endpackage

`default_nettype wire

// ===== hdl/mmcq_cell.sv =====
// mmcq_cell: one slot of the coalescing queue plus one stage of the probe row
// depends on mmcq_pkg
`default_nettype none

module mmcq_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mmcq_pkg::probe_type probe_i,
   output mmcq_pkg::probe_type     probe_o,
   output mmcq_pkg::drain_type     drain_o
);

   logic                full_ff, full_in;
   mmcq_pkg::msg_type   msg_ff, msg_in;
   mmcq_pkg::probe_type probe_ff, probe_in;
   logic                is_drain;
   logic                match;

   assign is_drain = probe_i.mode == mmcq_pkg::MODE_DRAIN;
   assign match    = full_ff && (msg_ff == probe_i.msg);

   always_comb begin
      full_in  = full_ff;
      msg_in   = msg_ff;
      probe_in = probe_i;
      drain_o  = '0;
      if (probe_i.valid) begin
         if (is_drain) begin
            if (full_ff) begin
               drain_o.hit   = 1'b1;
               drain_o.byte0 = msg_ff.status_byte;
               drain_o.byte1 = msg_ff.first_data;
               drain_o.byte2 = (msg_ff.message_length == mmcq_pkg::FULL_LENGTH) ?
                               msg_ff.second_data : 8'd0;
               full_in       = 1'b0;
            end
         end else if (!probe_i.done) begin
            if (match) begin
               probe_in.done = 1'b1;
            end else if (!full_ff) begin
               // first empty slot takes the message
               msg_in        = probe_i.msg;
               full_in       = 1'b1;
               probe_in.done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= 1'b0;
         probe_ff <= '0;
      end else begin
         full_ff  <= full_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
   end

   assign probe_o = probe_ff;

endmodule

`default_nettype wire

// ===== hdl/midi_message_coalescing_queue.sv =====
// midi_message_coalescing_queue: top level, a row of slot cells and the result stage
// depends on mmcq_pkg and mmcq_cell
`default_nettype none

// Pending MIDI message table with duplicate suppression.
// Input: req_item is taken at a rising edge with start high and busy low.
// mode 0 enqueues: the item walks the cell row one slot per cycle, a full slot
// holding the same message or the first empty slot ends it, and one
// acknowledgement comes out with accepted set unless the full table held no copy.
// mode 1 drains: every full slot in index order is sent as a result and
// emptied; the final one carries last. A drain of an empty table gives nothing.
// Results: rsp_item is valid for exactly one cycle while rsp_strobe is high;
// the receiver cannot hold results off.
// Timing: busy rises at the accept edge and stays high while the probe
// crosses the row one cell per cycle, and drops once it leaves the last cell.
// The acknowledgement or last drained message shows in the cycle busy drops,
// so the next item can start right then.
// Each earlier drained message is held back until the next full cell gives
// up its message and comes out in the cycle after that.
// Reset: synchronous, empties every slot and clears the row and result stage.
module midi_message_coalescing_queue #(
   parameter int SLOT_COUNT = mmcq_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire mmcq_pkg::req_type req_item,
   output logic               rsp_strobe,
   output mmcq_pkg::rsp_type  rsp_item
);

   mmcq_pkg::probe_type probe [SLOT_COUNT+1];
   mmcq_pkg::drain_type drain [SLOT_COUNT];
   mmcq_pkg::drain_type hit;
   mmcq_pkg::probe_type tail;
   logic                accept;

   logic                busy_ff, busy_in;
   logic                pend_valid_ff, pend_valid_in;
   mmcq_pkg::drain_type pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mmcq_pkg::rsp_type   rsp_ff, rsp_in;

   assign accept = start && !busy_ff;

   assign probe[0] = {accept, req_item.mode, 1'b0, req_item.status_byte,
                      req_item.first_data, req_item.second_data,
                      req_item.message_length};

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      mmcq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .probe_i (probe[g]),
         .probe_o (probe[g+1]),
         .drain_o (drain[g])
      );
   end

   // only the cell holding the probe can hit, so an or collects it
   always_comb begin
      hit = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit = hit | drain[i];
      end
   end

   assign tail = probe[SLOT_COUNT];

   always_comb begin
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      // hold one drained message back so the final one can be marked
      if (hit.hit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = {mmcq_pkg::KIND_DRAIN, 1'b0, pend_ff.byte0,
                            pend_ff.byte1, pend_ff.byte2, 1'b0};
         end
         pend_valid_in = 1'b1;
         pend_in       = hit;
      end
      if (tail.valid) begin
         busy_in = 1'b0;
         if (tail.mode == mmcq_pkg::MODE_ENQUEUE) begin
            rsp_valid_in = 1'b1;
            rsp_in       = {mmcq_pkg::KIND_ACK, tail.done, 8'd0, 8'd0, 8'd0, 1'b1};
         end else if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = {mmcq_pkg::KIND_DRAIN, 1'b0, pend_ff.byte0,
                             pend_ff.byte1, pend_ff.byte2, 1'b1};
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/mmcq_checker.sv =====
// mmcq_checker: port-level assertions for the coalescing queue, bound to the top
// depends on mmcq_pkg and midi_message_coalescing_queue
`default_nettype none

module mmcq_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire mmcq_pkg::rsp_type rsp_item
);

   // an acknowledgement is always the only result of its item
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind == mmcq_pkg::KIND_ACK |-> rsp_item.last)
      else $error("acknowledgement without last");

   a_drain_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind == mmcq_pkg::KIND_DRAIN |-> !rsp_item.accepted)
      else $error("drained message with accepted set");

   // the final result shows as busy drops, earlier drained ones while busy
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.last == !busy))
      else $error("last flag disagrees with busy");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |=> !rsp_strobe)
      else $error("result right after a last result");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an accepted item");

endmodule

bind midi_message_coalescing_queue mmcq_checker u_mmcq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire
